// ===== hw/rtl/rmts_pkg.sv =====
// ----------------------------------------------------------------------------
// rmts_pkg
// Shared types, codes and helpers for the rate-monotonic tick scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package rmts_pkg;

    // default number of task slots
    localparam int unsigned MAX_TASKS_DEF = 8;

    // request codes
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // register indexes
    localparam logic CFG_TASK_COUNT = 1'b0;
    localparam logic CFG_RUN_LENGTH = 1'b1;

    // result kinds
    localparam logic [1:0] KIND_SEGMENT = 2'd0;
    localparam logic [1:0] KIND_LOST    = 2'd1;
    localparam logic [1:0] KIND_SUMMARY = 2'd2;

    // segment status codes
    localparam logic [2:0] SEG_FINISHED  = 3'd0;
    localparam logic [2:0] SEG_PREEMPTED = 3'd1;
    localparam logic [2:0] SEG_KILLED    = 3'd2;
    localparam logic [2:0] SEG_IDLE      = 3'd3;
    localparam logic [2:0] SEG_LOST      = 3'd4;

    // reset values of the registers
    localparam logic [3:0]  TASK_COUNT_RST = 4'd1;
    localparam logic [15:0] RUN_LENGTH_RST = 16'd100;

    typedef struct packed {
        logic        req_type;
        logic [2:0]  task_id;
        logic [15:0] task_period;
        logic [15:0] task_burst;
    } t_req;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  task_ref;
        logic [2:0]  seg_status;
        logic [15:0] seg_units;
        logic [15:0] lost_total;
        logic [15:0] done_total;
        logic        killed_flag;
        logic        last;
    } t_res;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_START,
        OP_REL,
        OP_SWITCH,
        OP_RUN,
        OP_ENDSEG,
        OP_SUM,
        OP_CLEAR,
        OP_FLUSH
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic cnt_zero;
        logic idx_last;
        logic time_over;
        logic run_over;
        logic best_v;
    } t_stat;

    // saturating increment
    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rate_monotonic_tick_scheduler.sv =====
// ----------------------------------------------------------------------------
// rate_monotonic_tick_scheduler
// Preemptive rate-monotonic scheduler stepped one tick per tick request item.
// ----------------------------------------------------------------------------
//  channel   handshake                     payload
//  request   start & !busy                 i_item   (t_req)
//  result    o_res_valid, one cycle        o_result (t_res)
//  config    i_cfg_valid & o_cfg_ready     i_cfg_index, i_cfg_data
//
//  a load is taken in the idle state; a tick walks accept, release scan of one
//  slot a cycle, switch, run step (skipped when no job is ready) and flush;
//  the end-of-run tick walks accept, segment, one summary a cycle, clear and
//  flush; task_count is capped at MAX_TASKS.
//  each result waits in a one-item hold until the next is formed or the flush,
//  so the last result of an item leaves in the cycle after the flush.
//  reset is synchronous and clears all job state; tables stay unwritten.
//  the receiver cannot stall; results are shown for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rate_monotonic_tick_scheduler #(
    parameter int unsigned MAX_TASKS = rmts_pkg::MAX_TASKS_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire rmts_pkg::t_req  i_item,
    output logic                 o_res_valid,
    output rmts_pkg::t_res       o_result,
    input  wire logic            i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire logic            i_cfg_index,
    input  wire logic [15:0]     i_cfg_data
);
    import rmts_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // controller
    rmts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_req_type (i_item.req_type),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .busy       (busy)
    );

    // datapath
    rmts_dp #(
        .MAX_TASKS (MAX_TASKS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_valid & o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_stat      (stat),
        .o_res_valid (o_res_valid),
        .o_result    (o_result)
    );

    assign o_cfg_ready = ~busy;

endmodule

`default_nettype wire

// ===== hw/rtl/rmts_ctrl.sv =====
// ----------------------------------------------------------------------------
// rmts_ctrl
// Sequencer: walks release scan, switch, run step, end report and flush.
// ----------------------------------------------------------------------------
`default_nettype none

module rmts_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    input  wire logic           i_req_type,
    input  wire rmts_pkg::t_stat i_stat,
    output rmts_pkg::t_cmd      o_cmd,
    output logic                busy
);
    import rmts_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_REL    = 8'b0000_0010,
        ST_SWITCH = 8'b0000_0100,
        ST_RUN    = 8'b0000_1000,
        ST_ENDSEG = 8'b0001_0000,
        ST_SUM    = 8'b0010_0000,
        ST_CLEAR  = 8'b0100_0000,
        ST_FLUSH  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    // next state and command
    always_comb begin
        n_state  = r_state;
        o_cmd.op = OP_NONE;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    if (i_req_type == REQ_LOAD) begin
                        o_cmd.op = OP_LOAD;
                    end else if (!i_stat.run_over) begin
                        o_cmd.op = OP_START;
                        if (i_stat.time_over) n_state = ST_ENDSEG;
                        else if (i_stat.cnt_zero) n_state = ST_SWITCH;
                        else n_state = ST_REL;
                    end
                end
            end
            ST_REL: begin
                o_cmd.op = OP_REL;
                if (i_stat.idx_last) n_state = ST_SWITCH;
            end
            ST_SWITCH: begin
                o_cmd.op = OP_SWITCH;
                n_state  = i_stat.best_v ? ST_RUN : ST_FLUSH;
            end
            ST_RUN: begin
                o_cmd.op = OP_RUN;
                n_state  = ST_FLUSH;
            end
            ST_ENDSEG: begin
                o_cmd.op = OP_ENDSEG;
                n_state  = i_stat.cnt_zero ? ST_CLEAR : ST_SUM;
            end
            ST_SUM: begin
                o_cmd.op = OP_SUM;
                if (i_stat.idx_last) n_state = ST_CLEAR;
            end
            ST_CLEAR: begin
                o_cmd.op = OP_CLEAR;
                n_state  = ST_FLUSH;
            end
            ST_FLUSH: begin
                o_cmd.op = OP_FLUSH;
                n_state  = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else r_state <= n_state;
    end

    assign busy = (r_state != ST_IDLE);

    // every tick item that starts the sequence ends in a flush, which returns to idle
    a_flush_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_FLUSH |=> r_state == ST_IDLE)
        else $error("flush not followed by idle");
    a_run_after_switch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_RUN |-> $past(r_state) == ST_SWITCH)
        else $error("run step without switch");
    a_sum_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_CLEAR |-> ($past(r_state) == ST_SUM || $past(r_state) == ST_ENDSEG))
        else $error("clear outside end report");

endmodule

`default_nettype wire

// ===== hw/rtl/rmts_dp.sv =====
// ----------------------------------------------------------------------------
// rmts_dp
// Datapath: task tables, job state, counters, slot scan and result holding.
// ----------------------------------------------------------------------------
`default_nettype none

module rmts_dp #(
    parameter int unsigned MAX_TASKS = rmts_pkg::MAX_TASKS_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire rmts_pkg::t_cmd  i_cmd,
    input  wire rmts_pkg::t_req  i_item,
    input  wire logic            i_cfg_we,
    input  wire logic            i_cfg_index,
    input  wire logic [15:0]     i_cfg_data,
    output rmts_pkg::t_stat      o_stat,
    output logic                 o_res_valid,
    output rmts_pkg::t_res       o_result
);
    import rmts_pkg::*;

    localparam int unsigned IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int unsigned CW = $clog2(MAX_TASKS + 1);
    localparam logic [3:0] IDLE_REF = 4'(MAX_TASKS);

    // task tables, written by loads only
    logic [15:0] r_period [MAX_TASKS];
    logic [15:0] r_burst  [MAX_TASKS];
    // job state
    logic [15:0] r_cd     [MAX_TASKS];
    logic [15:0] r_rem    [MAX_TASKS];
    logic        r_pend   [MAX_TASKS];
    logic [15:0] r_lost   [MAX_TASKS];
    logic [15:0] r_done   [MAX_TASKS];

    logic [3:0]  r_task_count;
    logic [15:0] r_run_length;
    logic [15:0] r_time;
    logic        r_run_v;
    logic [IW-1:0] r_run_idx;
    logic [15:0] r_seg;
    logic        r_run_over;
    logic [IW-1:0] r_idx;
    logic        r_best_v;
    logic [IW-1:0] r_best_idx;
    logic [15:0] r_best_per;
    logic        r_hold_v;
    t_res        r_hold;
    logic        r_strobe;
    t_res        r_out;

    logic [CW-1:0] cnt;
    logic [15:0] cd, per, bur, rem_dec;
    logic        pend, is_run, pend_new, fire, switch_diff;
    logic [IW-1:0] load_idx;
    logic        emit_v;
    t_res        emit_r;

    // active slot count and scan status
    assign cnt = (32'(r_task_count) > MAX_TASKS) ? CW'(MAX_TASKS) : CW'(r_task_count);
    assign o_stat.cnt_zero  = (cnt == '0);
    assign o_stat.idx_last  = ((CW'(r_idx) + CW'(1)) == cnt);
    assign o_stat.time_over = (r_time >= r_run_length);
    assign o_stat.run_over  = r_run_over;
    assign o_stat.best_v    = r_best_v;

    // slot under the scan index
    assign cd      = r_cd[r_idx];
    assign per     = r_period[r_idx];
    assign bur     = r_burst[r_idx];
    assign pend    = r_pend[r_idx];
    assign rem_dec = r_rem[r_idx] - 16'd1;
    assign is_run  = r_run_v && (r_run_idx == r_idx);
    assign fire    = (cd == 16'd0);
    assign pend_new = fire ? (bur != 16'd0) : pend;
    assign switch_diff = (r_best_v != r_run_v) || (r_best_v && (r_best_idx != r_run_idx));
    assign load_idx = IW'(i_item.task_id);

    // result produced by the current operation
    always_comb begin
        emit_v = 1'b0;
        emit_r = '0;
        case (i_cmd.op)
            OP_REL: begin
                if (fire && pend) begin
                    emit_v = 1'b1;
                    emit_r.kind = KIND_LOST;
                    emit_r.task_ref = 4'(r_idx);
                    emit_r.seg_status = SEG_LOST;
                    emit_r.seg_units = is_run ? r_seg : 16'd0;
                end
            end
            OP_SWITCH: begin
                if (switch_diff && (r_seg != 16'd0)) begin
                    emit_v = 1'b1;
                    emit_r.kind = KIND_SEGMENT;
                    emit_r.task_ref = r_run_v ? 4'(r_run_idx) : IDLE_REF;
                    emit_r.seg_status = r_run_v ? SEG_PREEMPTED : SEG_IDLE;
                    emit_r.seg_units = r_seg;
                end
            end
            OP_RUN: begin
                if (rem_dec == 16'd0) begin
                    emit_v = 1'b1;
                    emit_r.kind = KIND_SEGMENT;
                    emit_r.task_ref = 4'(r_idx);
                    emit_r.seg_status = SEG_FINISHED;
                    emit_r.seg_units = r_seg;
                end
            end
            OP_ENDSEG: begin
                if (r_run_v || (r_seg != 16'd0)) begin
                    emit_v = 1'b1;
                    emit_r.kind = KIND_SEGMENT;
                    emit_r.task_ref = r_run_v ? 4'(r_run_idx) : IDLE_REF;
                    emit_r.seg_status = r_run_v ? SEG_KILLED : SEG_IDLE;
                    emit_r.seg_units = r_seg;
                end
            end
            OP_SUM: begin
                emit_v = 1'b1;
                emit_r.kind = KIND_SUMMARY;
                emit_r.task_ref = 4'(r_idx);
                emit_r.seg_status = SEG_FINISHED;
                emit_r.lost_total = r_lost[r_idx];
                emit_r.done_total = r_done[r_idx];
                emit_r.killed_flag = pend;
            end
            default: emit_v = 1'b0;
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_task_count <= TASK_COUNT_RST;
            r_run_length <= RUN_LENGTH_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_TASK_COUNT) r_task_count <= i_cfg_data[3:0];
            else r_run_length <= i_cfg_data;
        end
    end

    // task tables
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD && 32'(i_item.task_id) < MAX_TASKS) begin
            r_period[load_idx] <= i_item.task_period;
            r_burst[load_idx]  <= i_item.task_burst;
        end
    end

    // scheduler state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_TASKS; i++) begin
                r_cd[i]   <= '0;
                r_rem[i]  <= '0;
                r_pend[i] <= 1'b0;
                r_lost[i] <= '0;
                r_done[i] <= '0;
            end
            r_time     <= '0;
            r_run_v    <= 1'b0;
            r_run_idx  <= '0;
            r_seg      <= '0;
            r_run_over <= 1'b0;
            r_idx      <= '0;
            r_best_v   <= 1'b0;
            r_best_idx <= '0;
            r_best_per <= '0;
        end else begin
            case (i_cmd.op)
                OP_LOAD: begin
                    if (32'(i_item.task_id) < MAX_TASKS) r_cd[load_idx] <= '0;
                end
                OP_START: begin
                    r_idx    <= '0;
                    r_best_v <= 1'b0;
                end
                OP_REL: begin
                    if (!fire) begin
                        r_cd[r_idx] <= cd - 16'd1;
                    end else begin
                        r_cd[r_idx] <= (per == 16'd0) ? 16'd0 : per - 16'd1;
                        if (pend) begin
                            r_lost[r_idx] <= sat_inc(r_lost[r_idx]);
                            if (is_run) begin
                                r_run_v <= 1'b0;
                                r_seg   <= '0;
                            end
                        end
                        if (bur == 16'd0) r_done[r_idx] <= sat_inc(r_done[r_idx]);
                        else r_rem[r_idx] <= bur;
                    end
                    r_pend[r_idx] <= pend_new;
                    if (pend_new && (!r_best_v || per < r_best_per)) begin
                        r_best_v   <= 1'b1;
                        r_best_idx <= r_idx;
                        r_best_per <= per;
                    end
                    r_idx <= r_idx + IW'(1);
                end
                OP_SWITCH: begin
                    if (switch_diff) begin
                        r_run_v   <= r_best_v;
                        r_run_idx <= r_best_idx;
                        r_seg     <= 16'd1;
                    end else begin
                        r_seg <= sat_inc(r_seg);
                    end
                    r_idx <= r_best_idx;
                    if (!r_best_v) r_time <= sat_inc(r_time);
                end
                OP_RUN: begin
                    r_rem[r_idx] <= rem_dec;
                    if (rem_dec == 16'd0) begin
                        r_done[r_idx] <= sat_inc(r_done[r_idx]);
                        r_pend[r_idx] <= 1'b0;
                        r_run_v <= 1'b0;
                        r_seg   <= '0;
                    end
                    r_time <= sat_inc(r_time);
                end
                OP_ENDSEG: r_idx <= '0;
                OP_SUM: r_idx <= r_idx + IW'(1);
                OP_CLEAR: begin
                    for (int i = 0; i < MAX_TASKS; i++) begin
                        r_pend[i] <= 1'b0;
                        r_rem[i]  <= '0;
                    end
                    r_run_v    <= 1'b0;
                    r_seg      <= '0;
                    r_run_over <= 1'b1;
                end
                default: r_idx <= r_idx;
            endcase
        end
    end

    // one-item hold so the final item of a request can carry last
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_v <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            if (emit_v) begin
                r_hold_v <= 1'b1;
                r_strobe <= r_hold_v;
            end else if (i_cmd.op == OP_FLUSH) begin
                r_hold_v <= 1'b0;
                r_strobe <= r_hold_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_v) begin
            r_hold <= emit_r;
            r_out  <= {r_hold[$bits(t_res)-1:1], 1'b0};
        end else if (i_cmd.op == OP_FLUSH) begin
            r_out <= {r_hold[$bits(t_res)-1:1], 1'b1};
        end
    end

    assign o_res_valid = r_strobe;
    assign o_result    = r_out;

    // the running job is always a pending job with work left
    a_run_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run_v |-> (r_pend[r_run_idx] && r_rem[r_run_idx] != 16'd0))
        else $error("running slot has no pending work");
    a_over_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run_over |-> !r_run_v)
        else $error("job running after end of run");
    a_flush_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == OP_FLUSH |=> !r_hold_v)
        else $error("hold not emptied by flush");

endmodule

`default_nettype wire

// ===== tb/rmts_checker.sv =====
// ----------------------------------------------------------------------------
// rmts_checker
// Watches the request, result and config channels of the tick scheduler,
// predicts every result item from its own copy of the scheduler state and
// compares the results field by field, oldest expectation first.
// ----------------------------------------------------------------------------
`default_nettype none

module rmts_checker
    import rmts_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic        i_busy,
    input  wire t_req        i_item,
    input  wire logic        i_res_valid,
    input  wire t_res        i_result,
    input  wire logic        i_cfg_valid,
    input  wire logic        i_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    output int               o_fail_count,
    output int               o_outstanding
);

    localparam int          SLOTS    = 8;
    localparam logic [3:0]  IDLE_REF = 4'd8;

    // predicted scheduler state
    logic [15:0] period_q   [SLOTS];
    logic [15:0] burst_q    [SLOTS];
    logic [15:0] countdown_q[SLOTS];
    logic [15:0] remain_q   [SLOTS];
    logic        pending_q  [SLOTS];
    logic [15:0] lost_q     [SLOTS];
    logic [15:0] done_q     [SLOTS];
    logic [15:0] now_q;
    logic [3:0]  running_q;
    logic [15:0] seg_len_q;
    logic        finished_q;
    logic [3:0]  slots_cfg;
    logic [15:0] horizon_cfg;

    t_res expected_results[$];
    int   fails = 0;

    assign o_fail_count  = fails;
    assign o_outstanding = expected_results.size();

    function automatic logic [15:0] bump(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic t_res make_res(input logic [1:0] kind, input logic [3:0] ref_slot,
                                      input logic [2:0] st, input logic [15:0] units,
                                      input logic [15:0] lost, input logic [15:0] done,
                                      input logic killed);
        t_res r;
        r.kind        = kind;
        r.task_ref    = ref_slot;
        r.seg_status  = st;
        r.seg_units   = units;
        r.lost_total  = lost;
        r.done_total  = done;
        r.killed_flag = killed;
        r.last        = 1'b0;
        return r;
    endfunction

    // one accepted request item through the predicted scheduler
    task automatic schedule_item(input t_req rq);
        int          cnt;
        int          best;
        logic [15:0] units;
        t_res        batch[$];
        if (rq.req_type == REQ_LOAD) begin
            period_q[rq.task_id]    = rq.task_period;
            burst_q[rq.task_id]     = rq.task_burst;
            countdown_q[rq.task_id] = 16'd0;
            return;
        end
        if (finished_q) return;
        cnt = (slots_cfg > SLOTS) ? SLOTS : int'(slots_cfg);
        if (now_q >= horizon_cfg) begin
            // end of run: close the open segment, then one summary per slot
            if (running_q < IDLE_REF)
                batch.push_back(make_res(KIND_SEGMENT, running_q, SEG_KILLED,
                                         seg_len_q, 16'd0, 16'd0, 1'b0));
            else if (seg_len_q > 0)
                batch.push_back(make_res(KIND_SEGMENT, IDLE_REF, SEG_IDLE,
                                         seg_len_q, 16'd0, 16'd0, 1'b0));
            for (int i = 0; i < cnt; i++)
                batch.push_back(make_res(KIND_SUMMARY, 4'(i), SEG_FINISHED, 16'd0,
                                         lost_q[i], done_q[i], pending_q[i]));
            for (int i = 0; i < SLOTS; i++) begin
                pending_q[i] = 1'b0;
                remain_q[i]  = 16'd0;
            end
            running_q  = IDLE_REF;
            seg_len_q  = 16'd0;
            finished_q = 1'b1;
        end else begin
            // releases and lost deadlines
            for (int i = 0; i < cnt; i++) begin
                if (countdown_q[i] != 0) begin
                    countdown_q[i] = countdown_q[i] - 16'd1;
                    continue;
                end
                countdown_q[i] = (period_q[i] == 0) ? 16'd0 : period_q[i] - 16'd1;
                if (pending_q[i]) begin
                    units = 16'd0;
                    if (running_q == 4'(i)) begin
                        units     = seg_len_q;
                        seg_len_q = 16'd0;
                        running_q = IDLE_REF;
                    end
                    batch.push_back(make_res(KIND_LOST, 4'(i), SEG_LOST, units,
                                             16'd0, 16'd0, 1'b0));
                    lost_q[i]    = bump(lost_q[i]);
                    pending_q[i] = 1'b0;
                end
                if (burst_q[i] == 0) begin
                    done_q[i] = bump(done_q[i]);
                end else begin
                    pending_q[i] = 1'b1;
                    remain_q[i]  = burst_q[i];
                end
            end
            // shortest period wins, lowest slot on ties
            best = SLOTS;
            for (int i = 0; i < cnt; i++)
                if (pending_q[i] && (best == SLOTS || period_q[i] < period_q[best]))
                    best = i;
            if (4'(best) != running_q) begin
                if (seg_len_q > 0)
                    batch.push_back(make_res(KIND_SEGMENT, running_q,
                                             (running_q == IDLE_REF) ? SEG_IDLE
                                                                     : SEG_PREEMPTED,
                                             seg_len_q, 16'd0, 16'd0, 1'b0));
                running_q = 4'(best);
                seg_len_q = 16'd0;
            end
            // one unit of execution
            seg_len_q = bump(seg_len_q);
            if (best < SLOTS) begin
                remain_q[best] = remain_q[best] - 16'd1;
                if (remain_q[best] == 0) begin
                    batch.push_back(make_res(KIND_SEGMENT, 4'(best), SEG_FINISHED,
                                             seg_len_q, 16'd0, 16'd0, 1'b0));
                    done_q[best]    = bump(done_q[best]);
                    pending_q[best] = 1'b0;
                    running_q       = IDLE_REF;
                    seg_len_q       = 16'd0;
                end
            end
            now_q = bump(now_q);
        end
        if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
        foreach (batch[k]) expected_results.push_back(batch[k]);
    endtask

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s expected %0d actual %0d", name, exp_v, act_v);
            fails++;
        end
    endtask

    // reset, config copies, prediction and comparison
    always @(posedge i_clk) begin
        t_res e;
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                period_q[i]    = 16'd0;
                burst_q[i]     = 16'd0;
                countdown_q[i] = 16'd0;
                remain_q[i]    = 16'd0;
                pending_q[i]   = 1'b0;
                lost_q[i]      = 16'd0;
                done_q[i]      = 16'd0;
            end
            now_q       = 16'd0;
            running_q   = IDLE_REF;
            seg_len_q   = 16'd0;
            finished_q  = 1'b0;
            slots_cfg   = TASK_COUNT_RST;
            horizon_cfg = RUN_LENGTH_RST;
        end else begin
            if (i_res_valid) begin
                if (expected_results.size() == 0) begin
                    $error("result item with nothing expected: kind %0d ref %0d",
                           i_result.kind, i_result.task_ref);
                    fails++;
                end else begin
                    e = expected_results.pop_front();
                    check_field("kind", 16'(e.kind), 16'(i_result.kind));
                    check_field("task_ref", 16'(e.task_ref), 16'(i_result.task_ref));
                    check_field("seg_status", 16'(e.seg_status),
                                16'(i_result.seg_status));
                    check_field("seg_units",   e.seg_units,   i_result.seg_units);
                    check_field("lost_total",  e.lost_total,  i_result.lost_total);
                    check_field("done_total",  e.done_total,  i_result.done_total);
                    check_field("killed_flag", 16'(e.killed_flag),
                                16'(i_result.killed_flag));
                    check_field("last", 16'(e.last), 16'(i_result.last));
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_TASK_COUNT) slots_cfg = i_cfg_data[3:0];
                else horizon_cfg = i_cfg_data;
            end
            if (i_start && !i_busy) schedule_item(i_item);
        end
    end

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the rate-monotonic tick scheduler: loads every
// slot, runs directed and random tick/load phases over several task counts
// and run lengths with random gaps, then forces the end-of-run report.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import rmts_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int SETTLE      = 24;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        start       = 1'b0;
    t_req        i_item      = '0;
    logic        i_cfg_valid = 1'b0;
    logic        i_cfg_index = CFG_TASK_COUNT;
    logic [15:0] i_cfg_data  = 16'd0;
    logic        busy;
    logic        o_res_valid;
    t_res        o_result;
    logic        o_cfg_ready;
    int          fail_count;
    int          outstanding;
    int          cycles = 0;
    bit          gaps_on = 1'b1;

    rate_monotonic_tick_scheduler dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_res_valid(o_res_valid),
        .o_result   (o_result),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    rmts_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_item       (i_item),
        .i_res_valid  (o_res_valid),
        .i_result     (o_result),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_outstanding(outstanding)
    );

    always #2 i_clk = ~i_clk;

    // run watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // hand one item over, start stays high when no gap follows
    task automatic send_item(input t_req rq);
        int gap;
        gap = gaps_on ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_item <= rq;
        start  <= 1'b1;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic send_load(input logic [2:0] id, input logic [15:0] period,
                             input logic [15:0] burst);
        t_req rq;
        rq.req_type    = REQ_LOAD;
        rq.task_id     = id;
        rq.task_period = period;
        rq.task_burst  = burst;
        send_item(rq);
    endtask

    task automatic send_tick();
        t_req rq;
        rq.req_type    = REQ_TICK;
        rq.task_id     = 3'($urandom);
        rq.task_period = 16'($urandom);
        rq.task_burst  = 16'($urandom);
        send_item(rq);
    endtask

    // wait for all results and for any tick still in flight
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // mostly ticks, loads with short periods and bursts, some wide values
    task automatic random_phase(input int items);
        int pick;
        logic [15:0] period;
        logic [15:0] burst;
        gaps_on = ($urandom_range(0, 3) != 0);
        for (int n = 0; n < items; n++) begin
            if ($urandom_range(0, 99) < 72) begin
                send_tick();
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 85)      period = 16'($urandom_range(1, 12));
                else if (pick < 95) period = 16'($urandom);
                else                period = 16'd0;
                pick = $urandom_range(0, 99);
                if (pick < 80)      burst = 16'($urandom_range(0, 4));
                else if (pick < 90) burst = 16'($urandom);
                else                burst = 16'd0;
                send_load(3'($urandom), period, burst);
            end
        end
    endtask

    initial begin
        logic [3:0] counts[6];
        counts = '{4'd0, 4'd1, 4'd15, 4'($urandom_range(2, 7)), 4'd8,
                   4'($urandom_range(1, 15))};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_reg(CFG_TASK_COUNT, 16'd8);
        write_reg(CFG_RUN_LENGTH, 16'hFFFF);

        // directed: every slot loaded before any tick reads it
        send_load(3'd0, 16'd0,     16'd0);      // zero period, zero burst
        send_load(3'd1, 16'hFFFF,  16'hFFFF);
        send_load(3'd2, 16'd3,     16'd1);
        send_load(3'd3, 16'd3,     16'd2);      // tie with slot 2
        send_load(3'd4, 16'd2,     16'd3);      // overruns its deadline
        send_load(3'd5, 16'd5,     16'd0);
        send_load(3'd6, 16'd7,     16'd2);
        send_load(3'd7, 16'd4,     16'd1);
        repeat (8) send_tick();
        send_load(3'd7, 16'd1,     16'd2);      // reload while work is pending
        repeat (4) send_tick();
        send_load(3'd0, 16'd0,     16'd1);      // zero period hogs the processor
        repeat (3) send_tick();
        send_load(3'd0, 16'd9,     16'd1);
        drain();

        // random phases over several task counts
        foreach (counts[p]) begin
            write_reg(CFG_TASK_COUNT, {12'd0, counts[p]});
            if (p % 2 == 1)
                write_reg(CFG_RUN_LENGTH, 16'($urandom_range(2000, 65535)));
            random_phase(75);
            drain();
        end

        // a run length of one forces the end-of-run report
        write_reg(CFG_RUN_LENGTH, 16'd1);
        send_tick();
        send_tick();
        send_load(3'd2, 16'd3, 16'd1);
        send_tick();
        drain();

        if (fail_count == 0 && outstanding == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
hw/rtl/rmts_pkg.sv
hw/rtl/rmts_ctrl.sv
hw/rtl/rmts_dp.sv
hw/rtl/rate_monotonic_tick_scheduler.sv
tb/rmts_checker.sv
tb/tb.sv
